[rtl/chm_pkg.sv]
// ----------------------------------------------------------------------------
// chm_pkg
// Shared constants, types and the key hash for the chained hash map engine.
// ----------------------------------------------------------------------------
package chm_pkg;

	localparam int CAPACITY_DEF      = 256;
	localparam int BUCKETS_DEF       = 64;
	localparam int MAX_KEY_BYTES_DEF = 8;
	localparam int KEY_W             = 64;
	localparam int KLEN_W            = 4;
	localparam int VAL_W             = 32;
	localparam int CNT_W             = 9;

	typedef enum logic [1:0] {
		CMD_GET = 2'd0,
		CMD_SET = 2'd1,
		CMD_DEL = 2'd2,
		CMD_NOP = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_HEAD,
		BK_READ,
		BK_CMP,
		BK_ALLOC,
		BK_DONE
	} bk_state_t;

	// one hash round on one byte
	function automatic logic [31:0] oat_round(input logic [31:0] h, input logic [7:0] b);
		logic [31:0] t;
		t = h + {24'd0, b};
		t = t + (t << 10);
		t = t ^ (t >> 6);
		return t;
	endfunction

	function automatic logic [31:0] oat_final(input logic [31:0] h);
		logic [31:0] t;
		t = h + (h << 3);
		t = t ^ (t >> 11);
		t = t + (t << 15);
		return t;
	endfunction

endpackage

[rtl/chm_ram.sv]
// ----------------------------------------------------------------------------
// chm_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module chm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

[rtl/chm_front.sv]
// ----------------------------------------------------------------------------
// chm_front
// Accepts requests, masks the key, hashes it one byte a cycle and pushes a
// classified request into a two-deep queue.
// ----------------------------------------------------------------------------
module chm_front import chm_pkg::*; #(
	parameter int BUCKETS       = BUCKETS_DEF,
	parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       valid,
	output logic                       stall,
	input  logic [1:0]                 command,
	input  logic [KEY_W-1:0]           key,
	input  logic [KLEN_W-1:0]          key_length,
	input  logic signed [VAL_W-1:0]    value,
	output logic                       q_valid,
	input  logic                       q_pop,
	output logic [1:0]                 q_cmd,
	output logic [KEY_W-1:0]           q_key,
	output logic [KLEN_W-1:0]          q_len,
	output logic [VAL_W-1:0]           q_val,
	output logic [$clog2(BUCKETS)-1:0] q_bucket
);
	localparam int BW = $clog2(BUCKETS);
	localparam int QW = 2 + KEY_W + KLEN_W + VAL_W + BW;

	logic              busy_q;
	logic [1:0]        cmd_q;
	logic [KEY_W-1:0]  key_q;
	logic [KLEN_W-1:0] len_q;
	logic [VAL_W-1:0]  val_q;
	logic [31:0]       h_q;
	logic [KLEN_W-1:0] idx_q;
	logic [KLEN_W-1:0] len_c;
	logic [KEY_W-1:0]  mask_c;
	logic              hash_done;
	logic [31:0]       hfin;
	logic [QW-1:0]     qmem_q [2];
	logic              wp_q, rp_q;
	logic [1:0]        cnt_q;
	logic              push;
	logic [QW-1:0]     qout;

	always_comb begin
		len_c = (key_length > KLEN_W'(MAX_KEY_BYTES)) ? KLEN_W'(MAX_KEY_BYTES) : key_length;
		for (int i = 0; i < 8; i++)
			mask_c[8*i +: 8] = (KLEN_W'(i) < len_c) ? 8'hFF : 8'h00;
	end

	assign stall     = busy_q;
	assign hash_done = busy_q && (idx_q == len_q);
	assign push      = hash_done && (cnt_q != 2'd2);
	assign hfin      = oat_final(h_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (valid && !busy_q) begin
			busy_q <= 1'b1;
		end else if (push) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid && !busy_q) begin
			cmd_q <= command;
			key_q <= key & mask_c;
			len_q <= len_c;
			val_q <= value;
			h_q   <= '0;
			idx_q <= '0;
		end else if (busy_q && idx_q != len_q) begin
			h_q   <= oat_round(h_q, key_q[8*idx_q[2:0] +: 8]);
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (q_pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			qmem_q[wp_q] <= {cmd_q, key_q, len_q, val_q, hfin[BW-1:0]};
	end

	assign qout    = qmem_q[rp_q];
	assign q_valid = (cnt_q != 2'd0);
	assign {q_cmd, q_key, q_len, q_val, q_bucket} = qout;
endmodule

[rtl/chm_back.sv]
// ----------------------------------------------------------------------------
// chm_back
// Walks the bucket chain in memory and carries out get, set, delete and no-op.
// Holds one result in an output register.
// ----------------------------------------------------------------------------
module chm_back import chm_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int BUCKETS  = BUCKETS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	output logic                       q_pop,
	input  logic [1:0]                 q_cmd,
	input  logic [KEY_W-1:0]           q_key,
	input  logic [KLEN_W-1:0]          q_len,
	input  logic [VAL_W-1:0]           q_val,
	input  logic [$clog2(BUCKETS)-1:0] q_bucket,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic [1:0]                 status,
	output logic signed [VAL_W-1:0]    value_out,
	output logic [CNT_W-1:0]           entry_count
);
	localparam int AW = $clog2(CAPACITY);
	localparam int LW = AW + 1;
	localparam int BW = $clog2(BUCKETS);
	localparam int EW = KEY_W + KLEN_W + VAL_W + LW;
	localparam logic [LW-1:0] NIL = LW'(CAPACITY);

	bk_state_t state_q, state_d;

	logic [BUCKETS-1:0] hvalid_q;
	logic [LW:0]        cnt_q;
	logic [AW:0]        init_q;
	logic [LW-1:0]      cur_q, prev_q;

	logic          h_we;
	logic [BW-1:0] h_addr;
	logic [LW-1:0] h_wdata, h_rdata, head_c;

	logic          e_we;
	logic [AW-1:0] e_addr;
	logic [EW-1:0] e_wdata, e_rdata;
	logic [KEY_W-1:0]  e_key;
	logic [KLEN_W-1:0] e_len;
	logic [VAL_W-1:0]  e_val;
	logic [LW-1:0]     e_link;

	logic          f_we;
	logic [AW-1:0] f_addr, f_wdata, f_rdata;

	logic          init_busy, match, fin;
	logic [1:0]    st_d;
	logic [VAL_W-1:0] vo_d;
	logic [LW-1:0] link_q;

	assign init_busy = !init_q[AW];
	assign {e_key, e_len, e_val, e_link} = e_rdata;
	assign head_c = hvalid_q[h_addr] ? h_rdata : NIL;
	assign match  = (e_len == q_len) && (e_key == q_key);

	chm_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_heads (
		.clk, .we(h_we), .addr(h_addr), .wdata(h_wdata), .rdata(h_rdata));
	chm_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_entries (
		.clk, .we(e_we), .addr(e_addr), .wdata(e_wdata), .rdata(e_rdata));
	chm_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_free (
		.clk, .we(f_we), .addr(f_addr), .wdata(f_wdata), .rdata(f_rdata));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE:  if (q_valid && !init_busy && !result_valid) state_d = BK_HEAD;
			BK_HEAD:  state_d = BK_READ;
			BK_READ:  state_d = (cur_q == NIL) ? BK_ALLOC : BK_CMP;
			BK_CMP:   state_d = match ? BK_ALLOC : BK_READ;
			BK_ALLOC: state_d = BK_DONE;
			BK_DONE:  state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	// memory ports and result
	always_comb begin
		h_we = 1'b0; h_addr = q_bucket; h_wdata = cur_q;
		e_we = 1'b0; e_addr = cur_q[AW-1:0]; e_wdata = e_rdata;
		f_we = 1'b0; f_addr = AW'(CAPACITY - 1) - cnt_q[AW-1:0]; f_wdata = cur_q[AW-1:0];
		st_d = ST_OK; vo_d = '0; fin = 1'b0;
		if (init_busy) begin
			f_we = 1'b1; f_addr = init_q[AW-1:0];
			f_wdata = AW'(CAPACITY - 1) - init_q[AW-1:0];
		end
		unique case (state_q)
			BK_ALLOC: begin
				fin = 1'b1;
				priority if (q_cmd == CMD_NOP) begin
					st_d = ST_OK;
				end else if (q_cmd == CMD_GET) begin
					if (cur_q == NIL) st_d = ST_NOTFOUND;
					else vo_d = e_val;
				end else if (q_cmd == CMD_SET) begin
					if (cur_q != NIL) begin
						e_we = 1'b1; e_wdata = {e_key, e_len, q_val, e_link};
					end else if (cnt_q >= (LW+1)'(CAPACITY)) begin
						st_d = ST_FULL;
					end else begin
						e_we = 1'b1; e_addr = f_rdata;
						e_wdata = {q_key, q_len, q_val, head_c};
						h_we = 1'b1; h_wdata = {1'b0, f_rdata};
					end
				end else begin
					if (cur_q == NIL) begin
						st_d = ST_NOTFOUND;
					end else if (prev_q == NIL) begin
						h_we = 1'b1; h_wdata = e_link;
					end else begin
						e_addr = prev_q[AW-1:0];
					end
				end
			end
			BK_DONE: begin
				if (q_cmd == CMD_DEL && cur_q != NIL && prev_q != NIL) begin
					e_we = 1'b1; e_addr = prev_q[AW-1:0];
					e_wdata = {e_key, e_len, e_val, link_q};
				end
				if (q_cmd == CMD_DEL && cur_q != NIL) begin
					f_we = 1'b1; f_addr = AW'(CAPACITY - 1) - cnt_q[AW-1:0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			hvalid_q     <= '0;
			cnt_q        <= '0;
			init_q       <= '0;
			result_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (init_busy)
				init_q <= init_q + 1'b1;
			if (h_we)
				hvalid_q[h_addr] <= 1'b1;
			if (result_valid && !result_stall)
				result_valid <= 1'b0;
			if (fin) begin
				result_valid <= 1'b1;
				if (q_cmd == CMD_SET && cur_q == NIL && st_d == ST_OK)
					cnt_q <= cnt_q + 1'b1;
				else if (q_cmd == CMD_DEL && cur_q != NIL)
					cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_HEAD: begin cur_q <= (q_cmd == CMD_NOP) ? NIL : head_c; prev_q <= NIL; end
			BK_CMP:  if (!match) begin prev_q <= cur_q; cur_q <= e_link; end
			BK_ALLOC: link_q <= e_link;
			default: ;
		endcase
		if (fin) begin
			status    <= st_d;
			value_out <= vo_d;
		end
	end

	// the free-stack read address must be stable into ALLOC; it is, cnt_q is fixed
	assign q_pop = (state_q == BK_DONE);
	assign entry_count = cnt_q[CNT_W-1:0];
endmodule

[rtl/chained_hash_map_engine.sv]
// A request is hashed in the front, then the back walks its bucket chain.
// Throughput: one request per chain walk in the back, which also waits for the
// previous result to be taken; front and back overlap.
// Reset: asynchronous, active low; afterwards a free-list fill pass over all CAPACITY
// slots runs before the first request is carried out.
// ----------------------------------------------------------------------------
// chained_hash_map_engine
// Key/value map with hashed buckets and chained entries.
// ----------------------------------------------------------------------------
module chained_hash_map_engine import chm_pkg::*; #(
	parameter int CAPACITY      = CAPACITY_DEF,
	parameter int BUCKETS       = BUCKETS_DEF,
	parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              command,
	input  logic [KEY_W-1:0]        key,
	input  logic [KLEN_W-1:0]       key_length,
	input  logic signed [VAL_W-1:0] value,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [1:0]              status,
	output logic signed [VAL_W-1:0] value_out,
	output logic [CNT_W-1:0]        entry_count
);
	logic                       q_valid, q_pop;
	logic [1:0]                 q_cmd;
	logic [KEY_W-1:0]           q_key;
	logic [KLEN_W-1:0]          q_len;
	logic [VAL_W-1:0]           q_val;
	logic [$clog2(BUCKETS)-1:0] q_bucket;

	chm_front #(.BUCKETS(BUCKETS), .MAX_KEY_BYTES(MAX_KEY_BYTES)) u_front (
		.clk, .arst_n, .valid(in_valid), .stall(in_stall), .command, .key,
		.key_length, .value, .q_valid, .q_pop, .q_cmd, .q_key, .q_len, .q_val, .q_bucket);

	chm_back #(.CAPACITY(CAPACITY), .BUCKETS(BUCKETS)) u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_cmd, .q_key, .q_len, .q_val, .q_bucket,
		.result_valid(out_valid), .result_stall(out_stall), .status, .value_out,
		.entry_count);
endmodule

[rtl/chm_checker.sv]
// ----------------------------------------------------------------------------
// chm_checker
// Port-level checks for the chained hash map engine.
// ----------------------------------------------------------------------------
module chm_checker import chm_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_stall,
	input logic [1:0]       status,
	input logic [VAL_W-1:0] value_out,
	input logic [CNT_W-1:0] entry_count
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(value_out))
		else $error("stalled result changed");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("bad status");
	a_vzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> value_out == '0)
		else $error("value on miss");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> entry_count == CNT_W'(CAPACITY_DEF))
		else $error("full below capacity");
endmodule

bind chained_hash_map_engine chm_checker u_chk (
	.clk, .arst_n, .out_valid, .out_stall, .status, .value_out, .entry_count);

[test/chained_hash_map_checker.sv]
// ----------------------------------------------------------------------------
// chained_hash_map_checker
// Watches the request and result channels of the hash map engine, keeps its own
// model of the key/value store, and compares every result against it.
// ----------------------------------------------------------------------------
module chained_hash_map_checker import chm_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_stall,
	input  logic [1:0]              command,
	input  logic [KEY_W-1:0]        key,
	input  logic [KLEN_W-1:0]       key_length,
	input  logic signed [VAL_W-1:0] value,
	input  logic                    out_valid,
	input  logic                    out_stall,
	input  logic [1:0]              status,
	input  logic signed [VAL_W-1:0] value_out,
	input  logic [CNT_W-1:0]        entry_count,
	output int                      failures,
	output int                      pending
);
	typedef struct packed {
		logic [1:0]       st;
		logic [VAL_W-1:0] val;
		logic [CNT_W-1:0] cnt;
	} reply_t;

	localparam int NIL = CAPACITY_DEF;

	reply_t      replies_due[$];
	int          heads[BUCKETS_DEF];
	logic [63:0] slot_key[CAPACITY_DEF];
	int          slot_len[CAPACITY_DEF];
	logic [31:0] slot_val[CAPACITY_DEF];
	int          slot_next[CAPACITY_DEF];
	int          free_slots[CAPACITY_DEF];
	int          stored;

	function automatic logic [31:0] key_hash(input logic [63:0] k, input int n);
		logic [31:0] h;
		h = 0;
		for (int i = 0; i < n; i++) begin
			h = h + {24'd0, k[8*i +: 8]};
			h = h + (h << 10);
			h = h ^ (h >> 6);
		end
		h = h + (h << 3);
		h = h ^ (h >> 11);
		h = h + (h << 15);
		return h;
	endfunction

	function automatic reply_t apply_request(input logic [1:0] c, input logic [63:0] k_in,
			input logic [3:0] l_in, input logic [31:0] v);
		reply_t r;
		int n, b, cur, prev, steps, s;
		logic [63:0] k;
		r = '0;
		n = (l_in > 8) ? 8 : l_in;
		k = (n >= 8) ? k_in : (k_in & ((64'd1 << (8 * n)) - 1));
		if (c != CMD_NOP) begin
			b = key_hash(k, n) % BUCKETS_DEF;
			prev = NIL;
			cur = heads[b];
			steps = 0;
			while (cur < NIL && steps < NIL) begin
				if (slot_len[cur] == n && slot_key[cur] == k)
					break;
				prev = cur;
				cur = slot_next[cur];
				steps++;
			end
			if (cur >= NIL || steps >= NIL)
				cur = NIL;
			if (c == CMD_GET) begin
				if (cur != NIL)
					r.val = slot_val[cur];
				else
					r.st = ST_NOTFOUND;
			end else if (c == CMD_SET) begin
				if (cur != NIL)
					slot_val[cur] = v;
				else if (stored >= NIL)
					r.st = ST_FULL;
				else begin
					s = free_slots[NIL - 1 - stored];
					slot_key[s] = k;
					slot_len[s] = n;
					slot_val[s] = v;
					slot_next[s] = heads[b];
					heads[b] = s;
					stored++;
				end
			end else begin
				if (cur == NIL)
					r.st = ST_NOTFOUND;
				else begin
					if (prev == NIL)
						heads[b] = slot_next[cur];
					else
						slot_next[prev] = slot_next[cur];
					stored--;
					free_slots[NIL - 1 - stored] = cur;
				end
			end
		end
		r.cnt = stored;
		return r;
	endfunction

	assign pending = replies_due.size();

	always @(posedge clk or negedge arst_n) begin
		reply_t e;
		if (!arst_n) begin
			failures <= 0;
			replies_due.delete();
			for (int i = 0; i < BUCKETS_DEF; i++)
				heads[i] = NIL;
			for (int i = 0; i < CAPACITY_DEF; i++) begin
				slot_next[i] = NIL;
				slot_len[i] = 0;
				slot_key[i] = 0;
				slot_val[i] = 0;
				free_slots[i] = CAPACITY_DEF - 1 - i;
			end
			stored = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					if (failures < 10)
						$display("unexpected result st=%0d val=%0d cnt=%0d",
							status, value_out, entry_count);
					failures <= failures + 1;
				end else begin
					e = replies_due.pop_front();
					if (e.st !== status || e.val !== value_out || e.cnt !== entry_count) begin
						if (failures < 10)
							$display("mismatch: exp st=%0d val=%0d cnt=%0d got st=%0d val=%0d cnt=%0d",
								e.st, $signed(e.val), e.cnt, status, value_out, entry_count);
						failures <= failures + 1;
					end
				end
			end
			if (in_valid && !in_stall)
				replies_due.push_back(apply_request(command, key, key_length, value));
		end
	end
endmodule

[test/chained_hash_map_engine_tb.sv]
// ----------------------------------------------------------------------------
// chained_hash_map_engine_tb
// Drives get/set/delete/no-op requests into the hash map engine with random
// gaps and result stalls, with a long result hold-off and a full-pool phase.
// ----------------------------------------------------------------------------
module chained_hash_map_engine_tb;
	import chm_pkg::*;

	logic                    clk, arst_n;
	logic                    in_valid, in_stall, out_valid, out_stall;
	logic [1:0]              command, status;
	logic [KEY_W-1:0]        key;
	logic [KLEN_W-1:0]       key_length;
	logic signed [VAL_W-1:0] value, value_out;
	logic [CNT_W-1:0]        entry_count;
	int                      failures, pending, cycles;
	bit                      hold_results;
	logic [63:0]             key_pool[32];

	chained_hash_map_engine dut (.*);
	chained_hash_map_checker chk (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 600000) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		out_stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_results) begin
				out_stall <= 1;
				repeat (400) @(posedge clk);
				hold_results = 0;
				out_stall <= 0;
			end else if ($urandom_range(3) == 0)
				out_stall <= ($urandom_range(1) == 0);
			else if ($urandom_range(1) == 0)
				out_stall <= 0;
			else begin
				out_stall <= 1;
				repeat ($urandom_range(16, 1)) @(posedge clk);
				out_stall <= 0;
			end
		end
	end

	task automatic send(input logic [1:0] c, input logic [63:0] k, input logic [3:0] n,
			input logic [31:0] v, input bit idle);
		int gap;
		gap = (idle && $urandom_range(2) == 0) ? int'($urandom_range(16)) : 0;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		command <= c;
		key <= k;
		key_length <= n;
		value <= v;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic random_request(input bit idle);
		logic [63:0] k;
		logic [1:0] c;
		k = key_pool[$urandom_range(31)];
		if ($urandom_range(9) == 0)
			k = {$urandom, $urandom};
		c = $urandom_range(9) == 0 ? CMD_NOP : cmd_t'($urandom_range(2));
		send(c, k, $urandom_range(9) == 0 ? 4'($urandom_range(15)) : 4'($urandom_range(8)),
			$urandom, idle);
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		command = CMD_GET;
		key = 0;
		key_length = 0;
		value = 0;
		hold_results = 0;
		for (int i = 0; i < 32; i++)
			key_pool[i] = {$urandom, $urandom};
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send(CMD_GET, 0, 0, 0, 0);
		send(CMD_SET, 0, 0, 32'h7fffffff, 0);
		send(CMD_GET, 64'hffff_ffff_ffff_ffff, 0, 0, 0);
		send(CMD_SET, 64'hffff_ffff_ffff_ffff, 8, 32'h80000000, 0);
		send(CMD_GET, 64'hffff_ffff_ffff_ffff, 15, 0, 0);
		send(CMD_SET, 64'hffff_ffff_ffff_ff12, 1, 32'hffffffff, 0);
		send(CMD_GET, 64'h12, 1, 0, 0);
		send(CMD_NOP, 64'h55, 3, 5, 0);
		send(CMD_SET, 64'h12, 1, 1, 0);
		send(CMD_GET, 64'hab12, 1, 0, 0);
		send(CMD_DEL, 64'h12, 1, 0, 0);
		send(CMD_DEL, 64'h12, 1, 0, 0);
		send(CMD_GET, 64'h12, 1, 0, 0);
		send(CMD_DEL, 0, 0, 0, 0);
		send(CMD_DEL, 64'hffff_ffff_ffff_ffff, 12, 0, 0);
		// fill the pool past capacity, then update and delete while full
		for (int i = 0; i < 260; i++)
			send(CMD_SET, {32'hA5A5_0000, i}, 8, i, $urandom_range(1));
		send(CMD_SET, {32'hA5A5_0000, 32'd3}, 8, 32'h1234, 0);
		send(CMD_GET, {32'hA5A5_0000, 32'd3}, 8, 0, 0);
		drain();
		hold_results = 1;
		for (int i = 0; i < 256; i++)
			send(CMD_DEL, {32'hA5A5_0000, i}, 8, 0, 0);
		drain();
		for (int i = 0; i < 500; i++)
			random_request(i % 100 > 20);
		in_valid <= 0;
		repeat (30) @(posedge clk);
		while (pending != 0) @(posedge clk);
		for (int i = 0; i < 30; i++)
			random_request(1);
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0 && cycles < 590000) @(posedge clk);
		repeat (100) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
